/* sv/psu_pkg.sv */
// shared types and constants for the png scanline unfilter
package psu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 8192;
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES = 1'b0,
        CFG_BPP       = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // codes above paeth reconstruct as none
    function automatic t_filter decode_filter(input logic [7:0] code);
        t_filter f;
        f = FILT_NONE;
        case (code)
            8'd1:    f = FILT_SUB;
            8'd2:    f = FILT_UP;
            8'd3:    f = FILT_AVG;
            8'd4:    f = FILT_PAETH;
            default: f = FILT_NONE;
        endcase
        return f;
    endfunction

endpackage

/* sv/psu_ram.sv */
// generic single write port ram with registered read
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/psu_predict.sv */
// filter predictor and byte reconstruction
module psu_predict (
    input  psu_pkg::t_filter i_filter,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_a,
    input  logic [7:0]       i_b,
    input  logic [7:0]       i_c,
    output logic [7:0]       o_result
);

    logic [8:0]        avg_sum;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] sc;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    assign sa = signed'({2'b00, i_a});
    assign sb = signed'({2'b00, i_b});
    assign sc = signed'({2'b00, i_c});

    always_comb begin
        // distances of p = a + b - c to a, b and c
        pa = sb - sc;
        pb = sa - sc;
        pc = sa + sb - sc - sc;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            paeth = i_a;
        end else if (pb <= pc) begin
            paeth = i_b;
        end else begin
            paeth = i_c;
        end
    end

    assign avg_sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        case (i_filter)
            psu_pkg::FILT_SUB:   pred = i_a;
            psu_pkg::FILT_UP:    pred = i_b;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth;
            default:             pred = 8'd0;
        endcase
    end

    assign o_result = i_byte + pred;

endmodule

/* sv/png_scanline_unfilter_core.sv */
// png scanline unfilter top level: row control, history, prior row memory
// an accepted data word passes through the compute stage register and then the output register
// throughput: one word per cycle while i_ready does not stall the output, filter words
//   included; set by the left neighbour loop through the predictor into the history register
// reset: synchronous active low; prior row entries beyond the written fill count
//   read as zero, so no clearing pass is needed after reset
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_image_start,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_pixel_byte,
    output logic                           o_row_end
);

    localparam int IW = $clog2(MAX_ROW_BYTES);
    localparam int LW = IW + 1;
    localparam int CW = (LW > psu_pkg::ROW_BYTES_W) ? LW : psu_pkg::ROW_BYTES_W;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // configuration
    logic [psu_pkg::ROW_BYTES_W-1:0] r_row_bytes;
    logic [psu_pkg::BPP_W-1:0]       r_bpp;

    // row control
    logic             r_expect_filter;
    logic [IW-1:0]    r_pos;
    psu_pkg::t_filter r_filter;
    logic             r_first_row;
    logic             r_row_start;
    logic [LW-1:0]    r_fill;

    // compute stage
    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic [IW-1:0]    r_s1_idx;
    logic             r_s1_last;
    psu_pkg::t_filter r_s1_filter;
    logic             r_s1_first;
    logic             r_s1_clear;
    logic             r_s1_fwd_hit;
    logic [7:0]       r_s1_fwd_data;
    logic             r_s1_filled;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // pixel histories, newest first
    logic [7:0] r_left   [MAX_PIXEL_BYTES];
    logic [7:0] r_upleft [MAX_PIXEL_BYTES];

    logic          in_acc;
    logic          data_acc;
    logic          s1_fire;
    logic          out_acc;
    logic [CW-1:0] row_cmp;
    logic [LW-1:0] row_len;
    logic [LW-1:0] pos_next;
    logic          last0;
    logic [3:0]    bpp_eff;
    logic [PW-1:0] bpp_sel;
    logic [7:0]    rd_data;
    logic [7:0]    a_val;
    logic [7:0]    b_val;
    logic [7:0]    c_val;
    logic [7:0]    result;

    assign o_cfg_ready = 1'b1;

    assign s1_fire  = r_s1_valid & (~r_out_valid | i_ready);
    assign o_ready  = ~r_s1_valid | s1_fire;
    assign in_acc   = i_valid & o_ready;
    assign data_acc = in_acc & ~r_expect_filter;
    assign out_acc  = r_out_valid & i_ready;

    // effective row length, clamped to 1..MAX_ROW_BYTES
    always_comb begin
        row_cmp = CW'(r_row_bytes);
        if (row_cmp == '0) begin
            row_cmp = CW'(1);
        end else if (row_cmp > CW'(MAX_ROW_BYTES)) begin
            row_cmp = CW'(MAX_ROW_BYTES);
        end
        row_len = row_cmp[LW-1:0];
    end

    assign pos_next = {1'b0, r_pos} + LW'(1);
    assign last0    = (pos_next >= row_len);

    // effective pixel distance, clamped to 1..MAX_PIXEL_BYTES
    always_comb begin
        bpp_eff = {1'b0, r_bpp};
        if (bpp_eff == 4'd0) begin
            bpp_eff = 4'd1;
        end else if (bpp_eff > 4'(MAX_PIXEL_BYTES)) begin
            bpp_eff = 4'(MAX_PIXEL_BYTES);
        end
        bpp_sel = PW'(bpp_eff - 4'd1);
    end

    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (result),
        .i_rd_en   (data_acc),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (r_s1_first) begin
            b_val = 8'd0;
        end else if (r_s1_fwd_hit) begin
            b_val = r_s1_fwd_data;
        end else if (r_s1_filled) begin
            b_val = rd_data;
        end else begin
            b_val = 8'd0;
        end
    end

    assign a_val = r_s1_clear ? 8'd0 : r_left[bpp_sel];
    assign c_val = r_s1_clear ? 8'd0 : r_upleft[bpp_sel];

    psu_predict u_predict (
        .i_filter (r_s1_filter),
        .i_byte   (r_s1_byte),
        .i_a      (a_val),
        .i_b      (b_val),
        .i_c      (c_val),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= psu_pkg::ROW_BYTES_W'(1);
            r_bpp       <= psu_pkg::BPP_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psu_pkg::CFG_ROW_BYTES: r_row_bytes <= i_cfg_data[psu_pkg::ROW_BYTES_W-1:0];
                psu_pkg::CFG_BPP:       r_bpp       <= i_cfg_data[psu_pkg::BPP_W-1:0];
                default:                r_bpp       <= r_bpp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_filter <= 1'b1;
            r_pos           <= '0;
            r_filter        <= psu_pkg::FILT_NONE;
            r_first_row     <= 1'b1;
            r_row_start     <= 1'b1;
        end else if (in_acc) begin
            if (r_expect_filter) begin
                r_filter        <= psu_pkg::decode_filter(i_data_byte);
                r_expect_filter <= 1'b0;
                r_pos           <= '0;
                r_row_start     <= 1'b1;
                if (i_image_start) begin
                    r_first_row <= 1'b1;
                end
            end else begin
                r_row_start <= 1'b0;
                if (last0) begin
                    r_expect_filter <= 1'b1;
                    r_first_row     <= 1'b0;
                end else begin
                    r_pos <= pos_next[IW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (data_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_s1_byte     <= i_data_byte;
            r_s1_idx      <= r_pos;
            r_s1_last     <= last0;
            r_s1_filter   <= r_filter;
            r_s1_first    <= r_first_row;
            r_s1_clear    <= r_row_start;
            // same entry written by the word ahead in this cycle
            r_s1_fwd_hit  <= s1_fire && (r_s1_idx == r_pos);
            r_s1_fwd_data <= result;
            r_s1_filled   <= ({1'b0, r_pos} < r_fill);
        end
    end

    // prior row fill count: entries at or above it were never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (s1_fire && ({1'b0, r_s1_idx} >= r_fill)) begin
            r_fill <= {1'b0, r_s1_idx} + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_left[0]   <= result;
            r_upleft[0] <= b_val;
            for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k]   <= r_s1_clear ? 8'd0 : r_left[k-1];
                r_upleft[k] <= r_s1_clear ? 8'd0 : r_upleft[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_byte <= result;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_byte = r_out_byte;
    assign o_row_end    = r_out_last;

endmodule
